FILE: rtl/grg_pkg.sv
// Package for the Givens rotation generator: cell payload types and constants.
// Used by the square-root cells, the divider cells and the top level.
`timescale 1ns / 1ps
package grg_pkg;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 31;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sqrt_t;

	typedef struct packed {
		logic [31:0] divisor;
		logic [32:0] rem_c;
		logic [32:0] rem_s;
		logic [30:0] q_c;
		logic [30:0] q_s;
	} div_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		logic [31:0] m;
		m = v[31] ? (~v + 32'd1) : v;
		return m;
	endfunction
endpackage

FILE: rtl/grg_sqrt_cell.sv
// One registered cell of the digit-by-digit integer square root.
// Depends on grg_pkg for the cell payload type.
`timescale 1ns / 1ps
module grg_sqrt_cell (
	input  logic           clk,
	input  grg_pkg::sqrt_t d,
	output grg_pkg::sqrt_t q
);
	logic [34:0] cur;
	logic [34:0] trial;
	logic        ge;

	assign cur   = {d.rem[32:0], d.rad[63:62]};
	assign trial = {1'b0, d.root, 2'b01};
	assign ge    = cur >= trial;

	always_ff @(posedge clk) begin
		q.rem  <= ge ? cur - trial : cur;
		q.root <= {d.root[30:0], ge};
		q.rad  <= {d.rad[61:0], 2'b00};
	end
endmodule

FILE: rtl/grg_div_cell.sv
// One registered cell of the restoring dividers for cosine and sine.
// Depends on grg_pkg for the cell payload type.
`timescale 1ns / 1ps
module grg_div_cell (
	input  logic          clk,
	input  grg_pkg::div_t d,
	output grg_pkg::div_t q
);
	logic [32:0] dvs;
	logic        ge_c;
	logic        ge_s;
	logic [32:0] nc;
	logic [32:0] ns;

	assign dvs  = {1'b0, d.divisor};
	assign ge_c = d.rem_c >= dvs;
	assign ge_s = d.rem_s >= dvs;
	assign nc   = ge_c ? d.rem_c - dvs : d.rem_c;
	assign ns   = ge_s ? d.rem_s - dvs : d.rem_s;

	always_ff @(posedge clk) begin
		q.divisor <= d.divisor;
		q.rem_c   <= {nc[31:0], 1'b0};
		q.rem_s   <= {ns[31:0], 1'b0};
		q.q_c     <= {d.q_c[29:0], ge_c};
		q.q_s     <= {d.q_s[29:0], ge_s};
	end
endmodule

FILE: rtl/givens_rotation_generator.sv
// Top level of the Givens rotation generator: squares, square-root chain,
// divider chain and output register. Depends on grg_pkg and the two cell modules.
`timescale 1ns / 1ps
// Usage: drive first_component and second_component (signed Q16.16) with start
// high for one cycle per item. busy is always low, so an item can be accepted
// in every cycle. Each item yields one result on cosine and sine (signed Q2.30)
// and radius (signed Q16.16, 33 bits), shown for exactly one cycle with done
// high. Throughput is one item per cycle. The path runs through the row of
// cells: the squaring and summing registers, 32 square-root cells that each
// settle one root bit, 31 divider cells that each settle one quotient bit of
// both cosine and sine, and the output register. Reset clears the valid marks
// in the pipeline and done; items in flight at reset are dropped. The receiver
// cannot stall, so results leave the block in order with no buffering.
module givens_rotation_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] first_component,
	input  logic [31:0] second_component,
	output logic        done,
	output logic [31:0] cosine,
	output logic [31:0] sine,
	output logic [32:0] radius
);
	localparam int NS = grg_pkg::SQRT_STEPS;
	localparam int ND = grg_pkg::DIV_STEPS;

	logic        vld_s1, vld_s2;
	logic [31:0] f_s1, g_s1, f_s2, g_s2;
	logic [63:0] sqf_s1, sqg_s1, sum_s2;
	logic [31:0] f_mag, g_mag;

	grg_pkg::sqrt_t sq_in;
	grg_pkg::sqrt_t sq_q [NS];
	logic [NS-1:0] sq_vld_q;
	logic [31:0]   sq_f_q [NS];
	logic [31:0]   sq_g_q [NS];

	grg_pkg::div_t dv_in;
	grg_pkg::div_t dv_q [ND];
	logic [ND-1:0] dv_vld_q;
	logic [31:0]   dv_f_q [ND];
	logic [31:0]   dv_g_q [ND];

	logic [31:0] fin_f, fin_g;
	logic [31:0] cos_mag, sin_mag;

	assign busy  = 1'b0;
	assign f_mag = grg_pkg::mag32(first_component);
	assign g_mag = grg_pkg::mag32(second_component);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		f_s1   <= first_component;
		g_s1   <= second_component;
		sqf_s1 <= {32'd0, f_mag} * {32'd0, f_mag};
		sqg_s1 <= {32'd0, g_mag} * {32'd0, g_mag};
		f_s2   <= f_s1;
		g_s2   <= g_s1;
		sum_s2 <= sqf_s1 + sqg_s1;
	end

	assign sq_in = '{rem: '0, root: '0, rad: sum_s2};

	for (genvar i = 0; i < NS; i++) begin : g_sqrt
		grg_sqrt_cell u_cell (
			.clk (clk),
			.d   ((i == 0) ? sq_in : sq_q[(i == 0) ? 0 : i-1]),
			.q   (sq_q[i])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_q[i] <= 1'b0;
			end else begin
				sq_vld_q[i] <= (i == 0) ? vld_s2 : sq_vld_q[(i == 0) ? 0 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			sq_f_q[i] <= (i == 0) ? f_s2 : sq_f_q[(i == 0) ? 0 : i-1];
			sq_g_q[i] <= (i == 0) ? g_s2 : sq_g_q[(i == 0) ? 0 : i-1];
		end
	end

	assign dv_in = '{
		divisor: sq_q[NS-1].root,
		rem_c:   {1'b0, grg_pkg::mag32(sq_f_q[NS-1])},
		rem_s:   {1'b0, grg_pkg::mag32(sq_g_q[NS-1])},
		q_c:     '0,
		q_s:     '0
	};

	for (genvar i = 0; i < ND; i++) begin : g_div
		grg_div_cell u_cell (
			.clk (clk),
			.d   ((i == 0) ? dv_in : dv_q[(i == 0) ? 0 : i-1]),
			.q   (dv_q[i])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_q[i] <= 1'b0;
			end else begin
				dv_vld_q[i] <= (i == 0) ? sq_vld_q[NS-1] : dv_vld_q[(i == 0) ? 0 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			dv_f_q[i] <= (i == 0) ? sq_f_q[NS-1] : dv_f_q[(i == 0) ? 0 : i-1];
			dv_g_q[i] <= (i == 0) ? sq_g_q[NS-1] : dv_g_q[(i == 0) ? 0 : i-1];
		end
	end

	assign fin_f   = dv_f_q[ND-1];
	assign fin_g   = dv_g_q[ND-1];
	assign cos_mag = {1'b0, dv_q[ND-1].q_c};
	assign sin_mag = {1'b0, dv_q[ND-1].q_s};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld_q[ND-1];
		end
	end

	always_ff @(posedge clk) begin
		if (fin_g == '0) begin
			cosine <= grg_pkg::ONE_Q30;
			sine   <= '0;
			radius <= {fin_f[31], fin_f};
		end else if (fin_f == '0) begin
			cosine <= '0;
			sine   <= grg_pkg::ONE_Q30;
			radius <= {fin_g[31], fin_g};
		end else begin
			cosine <= fin_f[31] ? (~cos_mag + 32'd1) : cos_mag;
			sine   <= fin_g[31] ? (~sin_mag + 32'd1) : sin_mag;
			radius <= {1'b0, dv_q[ND-1].divisor};
		end
	end
endmodule

FILE: rtl/grg_checker.sv
// Port-level checks for the Givens rotation generator, bound to the top level.
// Depends on grg_pkg for the unit constant.
`timescale 1ns / 1ps
module grg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] cosine,
	input logic [31:0] sine,
	input logic [32:0] radius
);
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 66)) else $error("result without a matching item");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(cosine) <= $signed(grg_pkg::ONE_Q30)) &&
			($signed(cosine) >= -$signed(grg_pkg::ONE_Q30)))
		else $error("cosine out of range");

	a_sin_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(sine) <= $signed(grg_pkg::ONE_Q30)) &&
			($signed(sine) >= -$signed(grg_pkg::ONE_Q30)))
		else $error("sine out of range");

	a_neg_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(done && radius[32]) |->
			((cosine == grg_pkg::ONE_Q30 && sine == '0) ||
			 (cosine == '0 && sine == grg_pkg::ONE_Q30)))
		else $error("negative radius outside a special case");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy) else $error("busy raised");
endmodule

bind givens_rotation_generator grg_checker u_grg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.cosine (cosine),
	.sine   (sine),
	.radius (radius)
);

FILE: tb/tb_top.sv
// Self-checking testbench for givens_rotation_generator: directed table then random items.
// Depends only on the RTL: expected results come from the table or a fixed-point predictor.
`timescale 1ns / 1ps
module tb_top;
	typedef struct {
		logic [31:0] cos_v;
		logic [31:0] sin_v;
		logic [32:0] rad_v;
	} rotation_t;

	typedef struct {
		logic [31:0] f;
		logic [31:0] g;
		bit          typed;
		rotation_t   want;
	} stim_row_t;

	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [31:0] MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] first_component = '0;
	logic [31:0] second_component = '0;
	logic        done;
	logic [31:0] cosine;
	logic [31:0] sine;
	logic [32:0] radius;

	rotation_t pending_rotations[$];
	int        mismatch_count = 0;
	int        result_count = 0;
	int        item_count = 0;
	int        cycle_count = 0;

	givens_rotation_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.first_component(first_component),
		.second_component(second_component),
		.done(done),
		.cosine(cosine),
		.sine(sine),
		.radius(radius)
	);

	always #2 clk = ~clk;

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned root;
		longint unsigned bt;
		root = 0;
		bt = 64'd1 << 62;
		while (bt > n)
			bt = bt >> 2;
		while (bt != 0) begin
			if (n >= root + bt) begin
				n = n - (root + bt);
				root = (root >> 1) + bt;
			end else begin
				root = root >> 1;
			end
			bt = bt >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] unit_ratio(input longint v, input longint unsigned r);
		longint unsigned m;
		longint unsigned q;
		m = (v < 0) ? longint'(-v) : longint'(v);
		q = (m << 30) / r;
		if (v < 0)
			q = -q;
		return q[31:0];
	endfunction

	function automatic rotation_t predict_rotation(input logic [31:0] f, input logic [31:0] g);
		rotation_t res;
		longint fs;
		longint gs;
		longint unsigned r;
		fs = longint'(signed'(f));
		gs = longint'(signed'(g));
		if (g == 0) begin
			res.cos_v = ONE_Q30;
			res.sin_v = '0;
			res.rad_v = {f[31], f};
		end else if (f == 0) begin
			res.cos_v = '0;
			res.sin_v = ONE_Q30;
			res.rad_v = {g[31], g};
		end else begin
			r = root_floor(longint'(fs * fs) + longint'(gs * gs));
			res.cos_v = unit_ratio(fs, r);
			res.sin_v = unit_ratio(gs, r);
			res.rad_v = r[32:0];
		end
		return res;
	endfunction

	task automatic report(input string what, input logic [32:0] got, input logic [32:0] want);
		$display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want, result_count);
		mismatch_count++;
	endtask

	task automatic send_item(input logic [31:0] f, input logic [31:0] g, input rotation_t want);
		start <= 1'b1;
		first_component <= f;
		second_component <= g;
		do
			@(posedge clk);
		while (busy);
		pending_rotations.push_back(want);
		item_count++;
	endtask

	task automatic idle_cycle();
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] random_operand();
		case ($urandom_range(0, 7))
			0: return 32'(signed'($urandom_range(0, 200)) - 100);
			1: return ($urandom_range(0, 1) != 0) ? MOST_NEG : MOST_POS;
			2: return 32'($urandom_range(0, 31'h7FFF)) << $urandom_range(0, 16);
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("givens_rotation_generator regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		rotation_t want;
		if (arst_n && done) begin
			result_count++;
			if (pending_rotations.size() == 0) begin
				report("unexpected result", radius, '0);
			end else begin
				want = pending_rotations.pop_front();
				if (cosine !== want.cos_v)
					report("cosine", {1'b0, cosine}, {1'b0, want.cos_v});
				if (sine !== want.sin_v)
					report("sine", {1'b0, sine}, {1'b0, want.sin_v});
				if (radius !== want.rad_v)
					report("radius", radius, want.rad_v);
			end
		end
	end

	initial begin
		stim_row_t table_rows[$];
		stim_row_t row;
		rotation_t want;
		logic [31:0] f;
		logic [31:0] g;
		int idle_pct[4];
		idle_pct = '{0, 50, 0, 31};

		table_rows.push_back('{32'd0, 32'd0, 1, '{ONE_Q30, 32'd0, 33'd0}});
		table_rows.push_back('{32'h0001_0000, 32'd0, 1, '{ONE_Q30, 32'd0, 33'h0_0001_0000}});
		table_rows.push_back('{MOST_NEG, 32'd0, 1, '{ONE_Q30, 32'd0, 33'h1_8000_0000}});
		table_rows.push_back('{MOST_POS, 32'd0, 1, '{ONE_Q30, 32'd0, 33'h0_7FFF_FFFF}});
		table_rows.push_back('{32'd0, 32'd1, 1, '{32'd0, ONE_Q30, 33'd1}});
		table_rows.push_back('{32'd0, MOST_NEG, 1, '{32'd0, ONE_Q30, 33'h1_8000_0000}});
		table_rows.push_back('{32'd0, MOST_POS, 1, '{32'd0, ONE_Q30, 33'h0_7FFF_FFFF}});
		table_rows.push_back('{32'd0, 32'hFFFF_FFFF, 1, '{32'd0, ONE_Q30, 33'h1_FFFF_FFFF}});
		table_rows.push_back('{MOST_NEG, MOST_NEG, 0, want});
		table_rows.push_back('{MOST_POS, MOST_POS, 0, want});
		table_rows.push_back('{MOST_NEG, MOST_POS, 0, want});
		table_rows.push_back('{MOST_POS, MOST_NEG, 0, want});
		table_rows.push_back('{32'd1, 32'd1, 0, want});
		table_rows.push_back('{32'hFFFF_FFFF, 32'd1, 0, want});
		table_rows.push_back('{32'd1, 32'hFFFF_FFFF, 0, want});
		table_rows.push_back('{32'd3, 32'd4, 0, want});
		table_rows.push_back('{32'hFFFD_0000, 32'hFFFC_0000, 0, want});
		table_rows.push_back('{32'd1, MOST_NEG, 0, want});
		table_rows.push_back('{MOST_NEG, 32'd1, 0, want});
		table_rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 0, want});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			row = table_rows[i];
			send_item(row.f, row.g, row.typed ? row.want : predict_rotation(row.f, row.g));
		end

		for (int phase = 0; phase < 4; phase++) begin
			for (int n = 0; n < 400; n++) begin
				while ($urandom_range(0, 99) < idle_pct[phase])
					idle_cycle();
				f = random_operand();
				g = random_operand();
				case ($urandom_range(0, 15))
					0: g = '0;
					1: f = '0;
					default: ;
				endcase
				send_item(f, g, predict_rotation(f, g));
			end
		end
		start <= 1'b0;

		while (pending_rotations.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items (directed extremes and zero cases, then random) and checked %0d results.",
			item_count, result_count);
		$display("Random phases used sender idle rates of 0, 50, 0 and 31 percent.");
		if (mismatch_count == 0) begin
			$display("givens_rotation_generator regression: pass");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("givens_rotation_generator regression: fail");
		end
		$finish;
	end
endmodule
